@@ design/hclp_pkg.sv @@
// Shared types, constants and character helpers for the hex color line parser.
package hclp_pkg;

	// Line geometry: '#' plus six hex digits.
	localparam int unsigned LINE_CAP = 7;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned ERR_LEN  = 20;
	localparam int unsigned TIDX_W   = 5;

	// Special characters.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;

	// Source select for the output beat.
	localparam logic [2:0] OSEL_ECHO  = 3'd0;
	localparam logic [2:0] OSEL_BS    = 3'd1;
	localparam logic [2:0] OSEL_SPACE = 3'd2;
	localparam logic [2:0] OSEL_CR    = 3'd3;
	localparam logic [2:0] OSEL_LF    = 3'd4;
	localparam logic [2:0] OSEL_TEXT  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       latch_rx;
		logic       store_char;
		logic       dec_count;
		logic       clr_count;
		logic       apply_color;
		logic       text_clr;
		logic       text_step;
		logic       load_out;
		logic [2:0] out_sel;
		logic       out_last;
		logic       out_changed;
	} hclp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_bs;
		logic is_eol;
		logic count_zero;
		logic count_full;
		logic line_ok;
		logic out_free;
		logic text_end;
	} hclp_sts_t;

	// Characters of the error message "Invalid color code" CR LF.
	function automatic logic [7:0] err_char(input logic [TIDX_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:    ch = 8'h49; // I
			5'd1:    ch = 8'h6E; // n
			5'd2:    ch = 8'h76; // v
			5'd3:    ch = 8'h61; // a
			5'd4:    ch = 8'h6C; // l
			5'd5:    ch = 8'h69; // i
			5'd6:    ch = 8'h64; // d
			5'd7:    ch = 8'h20;
			5'd8:    ch = 8'h63; // c
			5'd9:    ch = 8'h6F; // o
			5'd10:   ch = 8'h6C; // l
			5'd11:   ch = 8'h6F; // o
			5'd12:   ch = 8'h72; // r
			5'd13:   ch = 8'h20;
			5'd14:   ch = 8'h63; // c
			5'd15:   ch = 8'h6F; // o
			5'd16:   ch = 8'h64; // d
			5'd17:   ch = 8'h65; // e
			5'd18:   ch = CH_CR;
			5'd19:   ch = CH_LF;
			default: ch = CH_LF;
		endcase
		return ch;
	endfunction

	// True for '0'..'9' and 'A'..'F'.
	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]}) || (c inside {[8'h41:8'h46]});
	endfunction

	// Nibble value of a hex digit that is known to be valid.
	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [7:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

@@ design/hex_color_line_parser.sv @@
// Top level of the hex color line parser: controller plus datapath.
//
// Each received byte is taken in one beat while the block is idle and then
// answered with zero to 22 output beats: an echo, a backspace rub-out, or
// CR LF followed by the "Invalid color code" message when a finished line
// is not '#' and six uppercase hex digits. After a decode state the
// controller emits one character per cycle through a single output register
// while the output side takes them; an output stall holds it in its state.
// The next byte is accepted while the last output beat still waits in that
// register. The red, green and blue ports show the levels with every beat
// and carry a new color already on the closing beat of a valid line.
module hex_color_line_parser
	import hclp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       color_changed,
	output logic       last
);

	hclp_cmd_t cmd;
	hclp_sts_t sts;

	// Sequencer.
	hclp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Line storage, levels and output beat register.
	hclp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.color_changed (color_changed),
		.last          (last)
	);

endmodule

@@ design/hclp_ctrl.sv @@
// Controller state machine that sequences input decode and output beats.
module hclp_ctrl
	import hclp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hclp_sts_t sts,
	output hclp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_ECHO   = 4'd2;
	localparam logic [3:0] S_BS1    = 4'd3;
	localparam logic [3:0] S_BS2    = 4'd4;
	localparam logic [3:0] S_BS3    = 4'd5;
	localparam logic [3:0] S_CR     = 4'd6;
	localparam logic [3:0] S_LF     = 4'd7;
	localparam logic [3:0] S_TEXT   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_rx = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_bs) begin
					state_d = sts.count_zero ? S_IDLE : S_BS1;
				end else if (sts.is_eol) begin
					state_d = S_CR;
				end else begin
					state_d = sts.count_full ? S_IDLE : S_ECHO;
				end
			end
			S_ECHO: begin
				if (sts.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_sel    = OSEL_ECHO;
					cmd.out_last   = 1'b1;
					cmd.store_char = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_BS1: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_BS;
					state_d      = S_BS2;
				end
			end
			S_BS2: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_SPACE;
					state_d      = S_BS3;
				end
			end
			S_BS3: begin
				if (sts.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_sel   = OSEL_BS;
					cmd.out_last  = 1'b1;
					cmd.dec_count = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CR: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_CR;
					state_d      = S_LF;
				end
			end
			S_LF: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_LF;
					if (sts.line_ok) begin
						cmd.out_last    = 1'b1;
						cmd.out_changed = 1'b1;
						cmd.apply_color = 1'b1;
						cmd.clr_count   = 1'b1;
						state_d         = S_IDLE;
					end else begin
						cmd.text_clr = 1'b1;
						state_d      = S_TEXT;
					end
				end
			end
			S_TEXT: begin
				if (sts.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_sel   = OSEL_TEXT;
					cmd.out_last  = sts.text_end;
					cmd.text_step = 1'b1;
					if (sts.text_end) begin
						cmd.clr_count = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// An output beat is only loaded when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output beat loaded over a pending beat");

	// An accepted input beat is decoded in the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DECODE)
		else $error("accepted byte not decoded");

	// A character is never stored into a full line.
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_char |-> !sts.count_full)
		else $error("store into full line");

	// Backspace never removes from an empty line.
	a_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_count |-> !sts.count_zero)
		else $error("backspace on empty line");

endmodule

@@ design/hclp_dp.sv @@
// Datapath: line buffer, character count, color levels and output register.
module hclp_dp
	import hclp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  hclp_cmd_t  cmd,
	output hclp_sts_t  sts,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       color_changed,
	output logic       last
);

	logic [7:0]        rx_q;
	logic [7:0]        line_q [LINE_CAP];
	logic [CNT_W-1:0]  cnt_q;
	logic [TIDX_W-1:0] tidx_q;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic [7:0]        blue_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [7:0]        red_out_q;
	logic [7:0]        green_out_q;
	logic [7:0]        blue_out_q;
	logic              changed_q;
	logic              last_q;

	logic [7:0] new_red;
	logic [7:0] new_green;
	logic [7:0] new_blue;
	logic       digits_ok;
	logic [7:0] out_char;

	// Line check and hex conversion over the fixed buffer positions.
	always_comb begin
		digits_ok = 1'b1;
		for (int i = 1; i < LINE_CAP; i++) begin
			digits_ok = digits_ok & is_hex(line_q[i]);
		end
	end

	assign new_red   = {hex_nib(line_q[1]), hex_nib(line_q[2])};
	assign new_green = {hex_nib(line_q[3]), hex_nib(line_q[4])};
	assign new_blue  = {hex_nib(line_q[5]), hex_nib(line_q[6])};

	// Status back to the controller.
	always_comb begin
		sts.is_bs      = (rx_q == CH_BS);
		sts.is_eol     = (rx_q == CH_CR) || (rx_q == CH_LF);
		sts.count_zero = (cnt_q == '0);
		sts.count_full = (cnt_q == CNT_W'(LINE_CAP));
		sts.line_ok    = sts.count_full && (line_q[0] == CH_HASH) && digits_ok;
		sts.out_free   = !out_valid_q || out_ready;
		sts.text_end   = (tidx_q == TIDX_W'(ERR_LEN - 1));
	end

	// Character chosen for the next output beat.
	always_comb begin
		case (cmd.out_sel)
			OSEL_ECHO:  out_char = rx_q;
			OSEL_BS:    out_char = CH_BS;
			OSEL_SPACE: out_char = CH_SPACE;
			OSEL_CR:    out_char = CH_CR;
			OSEL_LF:    out_char = CH_LF;
			OSEL_TEXT:  out_char = err_char(tidx_q);
			default:    out_char = CH_LF;
		endcase
	end

	// Received byte and line buffer entries.
	always_ff @(posedge clk) begin
		if (cmd.latch_rx) begin
			rx_q <= rx_byte;
		end
		if (cmd.store_char) begin
			line_q[cnt_q] <= rx_q;
		end
	end

	// Character count, message index and color levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			tidx_q  <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else begin
			if (cmd.clr_count) begin
				cnt_q <= '0;
			end else if (cmd.store_char) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.dec_count) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.text_clr) begin
				tidx_q <= '0;
			end else if (cmd.text_step) begin
				tidx_q <= tidx_q + 1'b1;
			end
			if (cmd.apply_color) begin
				red_q   <= new_red;
				green_q <= new_green;
				blue_q  <= new_blue;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; the colors already show a new line's levels.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_byte_q  <= out_char;
			red_out_q   <= cmd.apply_color ? new_red : red_q;
			green_out_q <= cmd.apply_color ? new_green : green_q;
			blue_out_q  <= cmd.apply_color ? new_blue : blue_q;
			changed_q   <= cmd.out_changed;
			last_q      <= cmd.out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign byte_valid    = 1'b1;
	assign red           = red_out_q;
	assign green         = green_out_q;
	assign blue          = blue_out_q;
	assign color_changed = changed_q;
	assign last          = last_q;

	// A color change is only ever reported on the closing beat of a line.
	a_changed_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && changed_q |-> last_q)
		else $error("color change on a non-final beat");

	// Applying a color always leaves the line count cleared in the following cycle.
	a_apply_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_color |=> cnt_q == '0)
		else $error("line not cleared after color update");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the hex color line parser: stimulus, prediction and checks.
module tb_top;
	import hclp_pkg::*;

	// Pending received character, with the idle cycles to spend before offering it.
	typedef struct packed {
		logic [7:0] ch;
		logic [4:0] gap;
		logic       drain;
	} rx_item_t;

	// One transmitted character as the parser should present it.
	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       changed;
		logic       fin;
	} tx_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       color_changed;
	logic       last;

	// Stimulus and scoreboard storage.
	rx_item_t   rx_pending[$];
	tx_beat_t   tx_chars_due[$];
	tx_beat_t   want;

	// Shadow copy of the parser state.
	logic [7:0] line_chars [0:6];
	int         held_count = 0;
	logic [7:0] lvl_red = 8'h00;
	logic [7:0] lvl_green = 8'h00;
	logic [7:0] lvl_blue = 8'h00;

	// Generator bookkeeping.
	int         gen_held = 0;
	int         productive = 0;
	bit         tx_calm = 1'b0;
	int         total_items = 0;

	// Handshake flags and run statistics.
	logic       in_taken = 1'b0;
	logic       out_taken = 1'b0;
	int         rx_accepted = 0;
	int         tx_seen = 0;
	int         mismatches = 0;
	int         colors_set = 0;
	int         lines_rejected = 0;

	// Sender and receiver pacing state.
	int         wait_left = -1;
	int         stall_left = 0;
	int         hold_left = 0;
	bit         long_hold_done = 1'b0;
	bit         rx_calm = 1'b0;

	hex_color_line_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.color_changed(color_changed),
		.last         (last)
	);

	always #4 clk = ~clk;

	// Uppercase hex digit test and its nibble value.
	function automatic bit upper_hex_ok(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] digit_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = (c <= "9") ? c - "0" : c - "A" + 8'd10;
		return v[3:0];
	endfunction

	function automatic void push_tx(input logic [7:0] ch, input logic changed,
			input logic fin);
		tx_beat_t t;
		t.ch = ch;
		t.r = lvl_red;
		t.g = lvl_green;
		t.b = lvl_blue;
		t.changed = changed;
		t.fin = fin;
		tx_chars_due.push_back(t);
	endfunction

	// Line editor: works out the characters sent back for one received character.
	function automatic void line_editor_step(input logic [7:0] c);
		int    i;
		bit    ok;
		string msg;
		msg = "Invalid color code";
		if (c == CH_BS) begin
			if (held_count == 0)
				return;
			held_count--;
			push_tx(CH_BS, 1'b0, 1'b0);
			push_tx(CH_SPACE, 1'b0, 1'b0);
			push_tx(CH_BS, 1'b0, 1'b1);
		end else if (c == CH_CR || c == CH_LF) begin
			push_tx(CH_CR, 1'b0, 1'b0);
			ok = (held_count == LINE_CAP) && (line_chars[0] == CH_HASH);
			for (i = 1; i < LINE_CAP; i++)
				if (!upper_hex_ok(line_chars[i]))
					ok = 1'b0;
			if (ok) begin
				lvl_red   = {digit_nibble(line_chars[1]), digit_nibble(line_chars[2])};
				lvl_green = {digit_nibble(line_chars[3]), digit_nibble(line_chars[4])};
				lvl_blue  = {digit_nibble(line_chars[5]), digit_nibble(line_chars[6])};
				colors_set++;
				push_tx(CH_LF, 1'b1, 1'b1);
			end else begin
				push_tx(CH_LF, 1'b0, 1'b0);
				for (i = 0; i < msg.len(); i++)
					push_tx(msg[i], 1'b0, 1'b0);
				push_tx(CH_CR, 1'b0, 1'b0);
				push_tx(CH_LF, 1'b0, 1'b1);
				lines_rejected++;
			end
			held_count = 0;
		end else if (held_count < LINE_CAP) begin
			line_chars[held_count] = c;
			held_count++;
			push_tx(c, 1'b0, 1'b1);
		end
	endfunction

	function automatic void cmp_field(input string what, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
		end
	endfunction

	// Stimulus helpers.
	function automatic logic [7:0] hex_char(input int v);
		return (v < 10) ? 8'(48 + v) : 8'(55 + v);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == CH_BS || c == CH_CR || c == CH_LF)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// Characters mostly just outside the accepted digit ranges, plus '#' and random bytes.
	function automatic logic [7:0] off_digit();
		case ($urandom_range(0, 6))
			0: return "/";
			1: return ":";
			2: return "@";
			3: return "G";
			4: return 8'($urandom_range(97, 102));
			5: return "#";
			default: return plain_byte();
		endcase
	endfunction

	function automatic logic [7:0] line_end();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	// Queues one character and tracks whether the parser will answer it.
	task automatic queue_byte(input logic [7:0] ch, input bit drain);
		rx_item_t it;
		if ($urandom_range(0, 29) == 0)
			tx_calm = !tx_calm;
		it.ch = ch;
		it.gap = tx_calm ? 5'd0 : 5'($urandom_range(0, 14));
		it.drain = drain;
		rx_pending.push_back(it);
		if (ch == CH_BS) begin
			if (gen_held > 0) begin
				gen_held--;
				productive++;
			end
		end else if (ch == CH_CR || ch == CH_LF) begin
			gen_held = 0;
			productive++;
		end else if (gen_held < LINE_CAP) begin
			gen_held++;
			productive++;
		end
	endtask

	task automatic queue_string(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_byte(s[i], 1'b0);
	endtask

	// One random line: mostly well-formed color codes, some flawed, some noise.
	task automatic queue_random_line(input bit drain);
		int         kind;
		int         pos;
		int         i;
		int         n;
		logic [7:0] ch;
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			pos = $urandom_range(1, 6);
			queue_byte(kind == 4 ? off_digit() : CH_HASH, drain);
			for (i = 1; i < LINE_CAP; i++) begin
				ch = hex_char($urandom_range(0, 15));
				if (kind == 6 && i == pos)
					ch = off_digit();
				if (kind == 5 && i == pos) begin
					queue_byte(plain_byte(), 1'b0);
					queue_byte(CH_BS, 1'b0);
				end
				queue_byte(ch, 1'b0);
			end
			if (kind == 7) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					queue_byte($urandom_range(0, 1) ? hex_char($urandom_range(0, 15)) : plain_byte(),
						1'b0);
			end
			queue_byte(line_end(), 1'b0);
		end else if (kind == 8) begin
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++)
				queue_byte($urandom_range(0, 4) == 0 ? CH_BS : plain_byte(), i == 0 && drain);
			queue_byte(line_end(), n == 0 && drain);
		end else begin
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				queue_byte(8'($urandom_range(0, 255)), i == 0 && drain);
		end
	endtask

	// Sender: offers queued characters at the falling edge, keeping each until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (rx_pending.size() == 0) begin
			in_valid <= 1'b0;
		end else if (rx_pending[0].drain && tx_chars_due.size() != 0) begin
			in_valid <= 1'b0;
		end else begin
			if (wait_left < 0)
				wait_left = rx_pending[0].gap;
			if (wait_left > 0) begin
				wait_left--;
				in_valid <= 1'b0;
			end else begin
				wait_left = -1;
				rx_byte <= rx_pending[0].ch;
				in_valid <= 1'b1;
				void'(rx_pending.pop_front());
			end
		end
	end

	// Receiver: random stalls per beat, plus one long hold-off to back the parser up.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (!long_hold_done && tx_seen >= 60) begin
				long_hold_done = 1'b1;
				hold_left = 300;
			end
			if (out_taken) begin
				if ($urandom_range(0, 29) == 0)
					rx_calm = !rx_calm;
				stall_left = rx_calm ? 0 : $urandom_range(0, 14);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: checks each output beat first, then feeds any accepted input beat to the editor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			out_taken <= 1'b1;
			tx_seen++;
			if (tx_chars_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output beat, expected none, actual %h", $time,
					out_byte);
			end else begin
				want = tx_chars_due.pop_front();
				cmp_field("out_byte", want.ch, out_byte);
				cmp_field("byte_valid", 8'd1, {7'd0, byte_valid});
				cmp_field("red", want.r, red);
				cmp_field("green", want.g, green);
				cmp_field("blue", want.b, blue);
				cmp_field("color_changed", {7'd0, want.changed}, {7'd0, color_changed});
				cmp_field("last", {7'd0, want.fin}, {7'd0, last});
			end
		end else begin
			out_taken <= 1'b0;
		end
		if (arst_n && in_valid && in_ready) begin
			in_taken <= 1'b1;
			rx_accepted++;
			line_editor_step(rx_byte);
		end else begin
			in_taken <= 1'b0;
		end
	end

	// Stimulus build, reset and end of run.
	initial begin
		int i;
		for (i = 0; i < LINE_CAP; i++)
			line_chars[i] = 8'h00;

		// Directed: empty backspace, a full valid line with a dropped extra, edits,
		// extreme byte values, lowercase digits and an empty line.
		queue_byte(CH_BS, 1'b0);
		queue_string("#FF00A9Z");
		queue_byte(CH_BS, 1'b0);
		queue_byte("9", 1'b0);
		queue_byte(CH_CR, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(CH_BS, 1'b0);
		queue_byte(CH_BS, 1'b0);
		queue_byte(CH_BS, 1'b0);
		queue_string("#ab");
		queue_byte(CH_LF, 1'b0);
		queue_byte(CH_LF, 1'b0);

		// Random lines; the first one waits for the directed part to drain.
		queue_random_line(1'b1);
		while (productive < 170)
			queue_random_line($urandom_range(0, 24) == 0);
		total_items = rx_pending.size();

		repeat (5) @(posedge clk);
		#1 arst_n = 1'b1;

		while (rx_accepted != total_items || tx_chars_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d received characters and %0d transmitted beats,",
			rx_accepted, tx_seen);
		$display("with %0d color updates and %0d rejected lines.", colors_set,
			lines_rejected);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3200000;
		$display("Timeout with %0d beats still outstanding", tx_chars_due.size());
		$display("FAILURE");
		$finish;
	end

endmodule
